>>> hw/rtl/periodic_timer_with_ms_counter_regs_assert.svh
// Assertion macros used by the timer top level.
// Each check is clocked on clk and held off while rst_n is low.
// Files that assert include this header by its bare name.
`ifndef PERIODIC_TIMER_WITH_MS_COUNTER_REGS_ASSERT_SVH
`define PERIODIC_TIMER_WITH_MS_COUNTER_REGS_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define PTMR_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("timer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PTMR_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("timer assertion failed");

`else

`define PTMR_ASSERT_NOW(lbl, pre, post)

`define PTMR_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

>>> hw/rtl/ptmr_pkg.sv
// Shared types and constants for the periodic timer block.
// Used by ptmr_core, the top level and the testbench; depends on nothing.
package ptmr_pkg;

  localparam int DATA_W   = 32;
  localparam int OFFSET_W = 12;
  localparam int MODE_W   = 2;
  localparam int TPM_W    = 16;
  localparam int PADDR_W  = 3;

  // Item kinds carried on the mode field.
  typedef enum logic [MODE_W-1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_TICK  = 2'd2
  } mode_t;

  // Bank select codes.
  localparam logic BANK_TIMER = 1'b0;
  localparam logic BANK_SYS   = 1'b1;

  // Timer bank register offsets.
  localparam logic [OFFSET_W-1:0] OFS_RELOAD  = 12'h040;
  localparam logic [OFFSET_W-1:0] OFS_CONTROL = 12'h048;
  localparam logic [OFFSET_W-1:0] OFS_IRQ     = 12'h04c;

  // System counter bank register offsets.
  localparam logic [OFFSET_W-1:0] OFS_MS_COUNT = 12'h004;
  localparam logic [OFFSET_W-1:0] OFS_SYS_CTRL = 12'h008;
  localparam logic [OFFSET_W-1:0] OFS_MS_ECHO  = 12'h00c;

  // Control word bits that run the countdown, and the fallback period.
  localparam logic [DATA_W-1:0] RUN_MASK       = 32'h0000_00c0;
  localparam logic [DATA_W-1:0] DEFAULT_PERIOD = 32'd26000;
  localparam logic [TPM_W-1:0]  TPM_RESET      = 16'd26000;

  // Interrupt register bit positions.
  localparam int IRQ_EN_BIT  = 0;
  localparam int IRQ_CLR_BIT = 3;

  // Configuration register word index.
  localparam logic CFG_TICKS_PER_MS = 1'b0;

  // One item as handed to the core.
  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic                bank;
    logic [OFFSET_W-1:0] offset;
    logic [DATA_W-1:0]   write_data;
  } step_t;

  // One result as produced by the core.
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq_level;
  } result_t;

endpackage

>>> hw/rtl/ptmr_core.sv
// Register state and combinational step logic of the periodic timer.
// Depends on ptmr_pkg for the item and result types and the register map.
module ptmr_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step_en,
  input  ptmr_pkg::step_t                 step,
  input  logic [ptmr_pkg::TPM_W-1:0]      ticks_per_ms,
  output ptmr_pkg::result_t               result,
  output logic                            irq_now
);
  import ptmr_pkg::*;

  logic [DATA_W-1:0] reload_r, reload_nxt;
  logic [DATA_W-1:0] control_r, control_nxt;
  logic              irq_enable_r, irq_enable_nxt;
  logic              irq_pending_r, irq_pending_nxt;
  logic [DATA_W-1:0] down_count_r, down_count_nxt;
  logic [DATA_W-1:0] sys_ctrl_r, sys_ctrl_nxt;
  logic              ms_echo_r, ms_echo_nxt;
  logic [DATA_W-1:0] ms_count_r, ms_count_nxt;
  logic [TPM_W-1:0]  prescale_r, prescale_nxt;

  logic [DATA_W-1:0] period_cur;
  logic [DATA_W-1:0] period_wd;
  logic              running;
  logic [TPM_W-1:0]  prescale_inc;
  logic              ms_roll;
  logic [DATA_W-1:0] read_data;

  // Period in use now, and the one a reload write would set.
  assign period_cur   = (reload_r != '0) ? reload_r : DEFAULT_PERIOD;
  assign period_wd    = (step.write_data != '0) ? step.write_data : DEFAULT_PERIOD;
  assign running      = (control_r & RUN_MASK) != '0;

  // The prescaler wraps at 16 bits; a zero limit behaves as one.
  assign prescale_inc = prescale_r + TPM_W'(1);
  assign ms_roll      = (prescale_inc >= ticks_per_ms) || (prescale_inc == '0);

  // Next state and read data for the item presented this cycle.
  always_comb begin
    reload_nxt      = reload_r;
    control_nxt     = control_r;
    irq_enable_nxt  = irq_enable_r;
    irq_pending_nxt = irq_pending_r;
    down_count_nxt  = down_count_r;
    sys_ctrl_nxt    = sys_ctrl_r;
    ms_echo_nxt     = ms_echo_r;
    ms_count_nxt    = ms_count_r;
    prescale_nxt    = prescale_r;
    read_data       = '0;

    case (step.mode)
      MODE_READ: begin
        if (step.bank == BANK_TIMER) begin
          case (step.offset)
            OFS_RELOAD:  read_data = reload_r;
            OFS_CONTROL: read_data = control_r;
            OFS_IRQ:     read_data = {29'd0, irq_pending_r, irq_pending_r, irq_enable_r};
            default:     read_data = '0;
          endcase
        end else begin
          case (step.offset)
            OFS_MS_COUNT: read_data = ms_count_r;
            OFS_SYS_CTRL: read_data = sys_ctrl_r;
            OFS_MS_ECHO:  read_data = {ms_count_r[DATA_W-1:1], ms_echo_r};
            default:      read_data = '0;
          endcase
        end
      end
      MODE_WRITE: begin
        if (step.bank == BANK_TIMER) begin
          case (step.offset)
            OFS_RELOAD: begin
              reload_nxt = step.write_data;
              if (running) begin
                down_count_nxt = period_wd;
              end
            end
            OFS_CONTROL: begin
              control_nxt = step.write_data;
              if ((step.write_data & RUN_MASK) != '0) begin
                down_count_nxt = period_cur;
              end
            end
            OFS_IRQ: begin
              irq_enable_nxt = step.write_data[IRQ_EN_BIT];
              if (step.write_data[IRQ_CLR_BIT]) begin
                irq_pending_nxt = 1'b0;
              end
            end
            default: ;
          endcase
        end else begin
          case (step.offset)
            OFS_SYS_CTRL: sys_ctrl_nxt = step.write_data;
            OFS_MS_ECHO:  ms_echo_nxt  = step.write_data[0];
            default: ;
          endcase
        end
      end
      MODE_TICK: begin
        if (ms_roll) begin
          prescale_nxt = '0;
          ms_count_nxt = ms_count_r + DATA_W'(1);
        end else begin
          prescale_nxt = prescale_inc;
        end
        // An underflow latches pending and reloads the full period.
        if (running) begin
          if (down_count_r <= DATA_W'(1)) begin
            irq_pending_nxt = 1'b1;
            down_count_nxt  = period_cur;
          end else begin
            down_count_nxt  = down_count_r - DATA_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // State registers, advanced once per accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r      <= DEFAULT_PERIOD;
      control_r     <= '0;
      irq_enable_r  <= 1'b0;
      irq_pending_r <= 1'b0;
      down_count_r  <= '0;
      sys_ctrl_r    <= '0;
      ms_echo_r     <= 1'b0;
      ms_count_r    <= '0;
      prescale_r    <= '0;
    end else if (step_en) begin
      reload_r      <= reload_nxt;
      control_r     <= control_nxt;
      irq_enable_r  <= irq_enable_nxt;
      irq_pending_r <= irq_pending_nxt;
      down_count_r  <= down_count_nxt;
      sys_ctrl_r    <= sys_ctrl_nxt;
      ms_echo_r     <= ms_echo_nxt;
      ms_count_r    <= ms_count_nxt;
      prescale_r    <= prescale_nxt;
    end
  end

  // Result of this item: read data and the interrupt line after the step.
  assign result.read_data = read_data;
  assign result.irq_level = irq_pending_nxt & irq_enable_nxt;
  assign irq_now          = irq_pending_r & irq_enable_r;

endmodule

>>> hw/rtl/periodic_timer_with_ms_counter_regs.sv
// Top level of the periodic timer with millisecond counter registers.
// Instantiates ptmr_core; uses ptmr_pkg and the assertion macro header.
//
// Each input beat is one bus read, one bus write or one timer clock tick, and
// each gives exactly one result beat with the read data (zero for anything but
// a known register read) and the interrupt level after the step. The block
// takes one beat per clock cycle, back to back, while the result side does not
// stall. A beat is held in the input register and is then stepped into the
// result register, where its result is presented. The rate is set by the
// timer state, which is read and updated combinationally for each item. With
// the result side stalled, one more input beat is held in the input register
// before in_stall rises. The ticks_per_ms register at byte address 0 of the
// APB port sets the millisecond prescaler; write it only while no beat is in
// flight.
`include "periodic_timer_with_ms_counter_regs_assert.svh"

module periodic_timer_with_ms_counter_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ptmr_pkg::MODE_W-1:0]       in_mode,
  input  logic                              in_bank,
  input  logic [ptmr_pkg::OFFSET_W-1:0]     in_offset,
  input  logic [ptmr_pkg::DATA_W-1:0]       in_write_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ptmr_pkg::DATA_W-1:0]       out_read_data,
  output logic                              out_irq_level,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ptmr_pkg::PADDR_W-1:0]      paddr,
  input  logic [ptmr_pkg::DATA_W-1:0]       pwdata,
  output logic [ptmr_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);
  import ptmr_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  step_t             s1_item_r;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_read_data_r;
  logic              out_irq_level_r;
  logic [TPM_W-1:0]  ticks_per_ms_r;

  logic              out_free;
  logic              s1_fire;
  logic              in_fire;
  logic              cfg_write;
  logic              cfg_tpm_write;
  result_t           core_result;
  logic              core_irq_now;

  // Handshake: the input register moves on whenever the result slot frees up.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_fire  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_fire);
  assign out_valid_nxt = s1_fire || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input beat capture.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.mode       <= in_mode;
      s1_item_r.bank       <= in_bank;
      s1_item_r.offset     <= in_offset;
      s1_item_r.write_data <= in_write_data;
    end
  end

  // Timer state and the per-item step logic.
  ptmr_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (s1_fire),
    .step         (s1_item_r),
    .ticks_per_ms (ticks_per_ms_r),
    .result       (core_result),
    .irq_now      (core_irq_now)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_read_data_r <= core_result.read_data;
      out_irq_level_r <= core_result.irq_level;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_irq_level = out_irq_level_r;

  // APB configuration port: one register, always ready.
  assign pready        = 1'b1;
  assign cfg_write     = psel && penable && pwrite && pready;
  assign cfg_tpm_write = cfg_write && (paddr[PADDR_W-1] == CFG_TICKS_PER_MS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_per_ms_r <= TPM_RESET;
    end else if (cfg_tpm_write) begin
      ticks_per_ms_r <= pwdata[TPM_W-1:0];
    end
  end

  assign prdata = (paddr[PADDR_W-1] == CFG_TICKS_PER_MS) ?
                  {{(DATA_W-TPM_W){1'b0}}, ticks_per_ms_r} : '0;

  // Anything but a read must return zero data.
  `PTMR_ASSERT_NEXT(a_nonread_zero, s1_fire && (s1_item_r.mode != MODE_READ), out_read_data == '0)
  // The registered interrupt level matches the core state right after the step.
  `PTMR_ASSERT_NEXT(a_irq_matches, s1_fire, out_irq_level == core_irq_now)
  // A configuration write lands in the prescaler limit.
  `PTMR_ASSERT_NEXT(a_cfg_write, cfg_tpm_write, ticks_per_ms_r == $past(pwdata[TPM_W-1:0]))

endmodule

>>> sim/periodic_timer_with_ms_counter_regs_tb.sv
// Self-checking testbench for periodic_timer_with_ms_counter_regs.
// Drives bus reads, writes and ticks, predicts every result beat in-line.
// Depends on ptmr_pkg and the top-level RTL only.
module periodic_timer_with_ms_counter_regs_tb;
  import ptmr_pkg::*;

  localparam int SEGMENTS          = 6;
  localparam int BEATS_PER_SEGMENT = 317;
  localparam int SETTLE_CYCLES     = 4;
  localparam int DIRECTED_ROWS     = 26;
  localparam logic [OFFSET_W-1:0] OFS_UNMAPPED = 12'hfff;

  // One row of the directed stimulus; known rows carry a hand-written result.
  typedef struct packed {
    step_t   beat;
    logic    known;
    result_t want;
  } directed_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [MODE_W-1:0]   in_mode;
  logic                in_bank;
  logic [OFFSET_W-1:0] in_offset;
  logic [DATA_W-1:0]   in_write_data;
  logic                out_valid;
  logic                out_stall;
  logic [DATA_W-1:0]   out_read_data;
  logic                out_irq_level;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Predicted timer state, kept at the block's widths.
  logic [TPM_W-1:0]  ticks_per_ms = TPM_RESET;
  logic [DATA_W-1:0] reload_reg   = DEFAULT_PERIOD;
  logic [DATA_W-1:0] ctrl_reg     = '0;
  logic              irq_en       = 1'b0;
  logic              irq_pend     = 1'b0;
  logic [DATA_W-1:0] countdown    = '0;
  logic [DATA_W-1:0] sys_ctrl     = '0;
  logic              echo_bit     = 1'b0;
  logic [DATA_W-1:0] ms_cnt       = '0;
  logic [TPM_W-1:0]  prescale_cnt = '0;

  result_t     due_results[$];
  int          mismatches    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  logic [TPM_W-1:0] tpm_plan [SEGMENTS] = '{16'd1, 16'd65535, 16'd3, 16'd2, 16'd1, 16'd9};

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{MODE_READ,  BANK_TIMER, OFS_RELOAD,   32'h0},        1'b1, '{DEFAULT_PERIOD, 1'b0}},
    '{'{MODE_READ,  BANK_TIMER, OFS_CONTROL,  32'h0},        1'b1, '{32'h0, 1'b0}},
    '{'{MODE_READ,  BANK_TIMER, OFS_IRQ,      32'h0},        1'b1, '{32'h0, 1'b0}},
    '{'{MODE_READ,  BANK_SYS,   OFS_MS_COUNT, 32'h0},        1'b1, '{32'h0, 1'b0}},
    '{'{MODE_READ,  BANK_SYS,   OFS_SYS_CTRL, 32'h0},        1'b1, '{32'h0, 1'b0}},
    '{'{MODE_READ,  BANK_SYS,   OFS_MS_ECHO,  32'h0},        1'b1, '{32'h0, 1'b0}},
    '{'{MODE_READ,  BANK_TIMER, OFS_UNMAPPED, 32'hffffffff}, 1'b1, '{32'h0, 1'b0}},
    '{'{MODE_WRITE, BANK_TIMER, OFS_RELOAD,   32'hffffffff}, 1'b1, '{32'h0, 1'b0}},
    '{'{MODE_READ,  BANK_TIMER, OFS_RELOAD,   32'h0},        1'b1, '{32'hffffffff, 1'b0}},
    '{'{MODE_WRITE, BANK_SYS,   OFS_SYS_CTRL, 32'hffffffff}, 1'b1, '{32'h0, 1'b0}},
    '{'{MODE_READ,  BANK_SYS,   OFS_SYS_CTRL, 32'h0},        1'b1, '{32'hffffffff, 1'b0}},
    '{'{MODE_WRITE, BANK_SYS,   OFS_MS_ECHO,  32'hffffffff}, 1'b1, '{32'h0, 1'b0}},
    '{'{MODE_READ,  BANK_SYS,   OFS_MS_ECHO,  32'h0},        1'b1, '{32'h1, 1'b0}},
    '{'{MODE_WRITE, BANK_SYS,   OFS_MS_COUNT, 32'hffffffff}, 1'b1, '{32'h0, 1'b0}},
    '{'{MODE_READ,  BANK_SYS,   OFS_MS_COUNT, 32'h0},        1'b1, '{32'h0, 1'b0}},
    '{'{MODE_WRITE, BANK_TIMER, OFS_RELOAD,   32'h2},        1'b1, '{32'h0, 1'b0}},
    '{'{MODE_WRITE, BANK_TIMER, OFS_IRQ,      32'h1},        1'b1, '{32'h0, 1'b0}},
    '{'{MODE_WRITE, BANK_TIMER, OFS_CONTROL,  32'h40},       1'b0, '{32'h0, 1'b0}},
    '{'{MODE_TICK,  BANK_TIMER, OFS_RELOAD,   32'h0},        1'b0, '{32'h0, 1'b0}},
    '{'{MODE_TICK,  BANK_SYS,   OFS_UNMAPPED, 32'hffffffff}, 1'b0, '{32'h0, 1'b0}},
    '{'{MODE_READ,  BANK_TIMER, OFS_IRQ,      32'h0},        1'b1, '{32'h7, 1'b1}},
    '{'{MODE_WRITE, BANK_TIMER, OFS_RELOAD,   32'h0},        1'b0, '{32'h0, 1'b0}},
    '{'{MODE_WRITE, BANK_TIMER, OFS_CONTROL,  32'h80},       1'b0, '{32'h0, 1'b0}},
    '{'{MODE_WRITE, BANK_TIMER, OFS_IRQ,      32'h8},        1'b1, '{32'h0, 1'b0}},
    '{'{MODE_WRITE, BANK_TIMER, OFS_CONTROL,  32'hffffff3f}, 1'b0, '{32'h0, 1'b0}},
    '{'{MODE_READ,  BANK_SYS,   OFS_UNMAPPED, 32'hffffffff}, 1'b1, '{32'h0, 1'b0}}
  };

  periodic_timer_with_ms_counter_regs i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_bank       (in_bank),
    .in_offset     (in_offset),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data),
    .out_irq_level (out_irq_level),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The countdown period; a zero reload value falls back to the default.
  function automatic logic [DATA_W-1:0] period_ticks();
    return (reload_reg != '0) ? reload_reg : DEFAULT_PERIOD;
  endfunction

  // Applies one beat to the predicted state and returns the result it gives.
  function automatic result_t timer_step(step_t s);
    result_t          r;
    logic [TPM_W-1:0] nxt;
    r.read_data = '0;
    if (s.mode == MODE_READ) begin
      if (s.bank == BANK_TIMER) begin
        case (s.offset)
          OFS_RELOAD:  r.read_data = reload_reg;
          OFS_CONTROL: r.read_data = ctrl_reg;
          OFS_IRQ:     r.read_data = {29'd0, irq_pend, irq_pend, irq_en};
          default:     r.read_data = '0;
        endcase
      end else begin
        case (s.offset)
          OFS_MS_COUNT: r.read_data = ms_cnt;
          OFS_SYS_CTRL: r.read_data = sys_ctrl;
          OFS_MS_ECHO:  r.read_data = {ms_cnt[DATA_W-1:1], echo_bit};
          default:      r.read_data = '0;
        endcase
      end
    end else if (s.mode == MODE_WRITE) begin
      if (s.bank == BANK_TIMER) begin
        case (s.offset)
          OFS_RELOAD: begin
            // A new reload value restarts a running count.
            reload_reg = s.write_data;
            if ((ctrl_reg & RUN_MASK) != '0) countdown = period_ticks();
          end
          OFS_CONTROL: begin
            ctrl_reg = s.write_data;
            if ((s.write_data & RUN_MASK) != '0) countdown = period_ticks();
          end
          OFS_IRQ: begin
            irq_en = s.write_data[IRQ_EN_BIT];
            if (s.write_data[IRQ_CLR_BIT]) irq_pend = 1'b0;
          end
          default: ;
        endcase
      end else begin
        case (s.offset)
          OFS_SYS_CTRL: sys_ctrl = s.write_data;
          OFS_MS_ECHO:  echo_bit = s.write_data[0];
          default: ;
        endcase
      end
    end else if (s.mode == MODE_TICK) begin
      // Millisecond prescaler; a wrap of the 16-bit count also rolls over.
      nxt = prescale_cnt + 1'b1;
      if (nxt >= ticks_per_ms || nxt == '0) begin
        prescale_cnt = '0;
        ms_cnt = ms_cnt + 1'b1;
      end else begin
        prescale_cnt = nxt;
      end
      // Periodic countdown while either run bit is set.
      if ((ctrl_reg & RUN_MASK) != '0) begin
        if (countdown <= 1) begin
          irq_pend = 1'b1;
          countdown = period_ticks();
        end else begin
          countdown = countdown - 1'b1;
        end
      end
    end
    r.irq_level = irq_pend & irq_en;
    return r;
  endfunction

  // Random beat: mostly ticks and accesses to mapped registers with shaped
  // data, the rest accesses at random offsets in either bank.
  function automatic step_t random_beat();
    step_t       s;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    s.mode = MODE_TICK;
    s.bank = 1'($urandom_range(0, 1));
    s.offset = OFFSET_W'($urandom_range(0, 4095));
    s.write_data = $urandom();
    if (pick >= 45 && pick < 90) begin
      s.mode = (pick < 68) ? MODE_READ : MODE_WRITE;
      case ($urandom_range(0, 5))
        0:       {s.bank, s.offset} = {BANK_TIMER, OFS_RELOAD};
        1:       {s.bank, s.offset} = {BANK_TIMER, OFS_CONTROL};
        2:       {s.bank, s.offset} = {BANK_TIMER, OFS_IRQ};
        3:       {s.bank, s.offset} = {BANK_SYS, OFS_MS_COUNT};
        4:       {s.bank, s.offset} = {BANK_SYS, OFS_SYS_CTRL};
        default: {s.bank, s.offset} = {BANK_SYS, OFS_MS_ECHO};
      endcase
      // Keep periods short so that underflows are frequent.
      if (s.bank == BANK_TIMER && s.offset == OFS_RELOAD) begin
        case ($urandom_range(0, 9))
          0:       s.write_data = '0;
          1:       ;
          default: s.write_data = DATA_W'($urandom_range(1, 24));
        endcase
      end
      if (s.bank == BANK_TIMER && s.offset == OFS_CONTROL)
        s.write_data[7:6] = ($urandom_range(0, 3) == 0) ? 2'b00 : 2'($urandom_range(1, 3));
    end else if (pick >= 90) begin
      s.mode = ($urandom_range(0, 1) == 0) ? MODE_READ : MODE_WRITE;
    end
    return s;
  endfunction

  // Presents one input beat, holds it until accepted and records its result.
  task automatic drive_beat(input step_t s, input logic known, input result_t want);
    result_t got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= s.mode;
    in_bank       <= s.bank;
    in_offset     <= s.offset;
    in_write_data <= s.write_data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = timer_step(s);
    due_results.push_back(known ? want : got);
    @(negedge clk);
  endtask

  // Lets every outstanding result drain, then lets the block settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_ticks_per_ms(input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * CFG_TICKS_PER_MS);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    ticks_per_ms = value[TPM_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Receiver stalls at random at the configured rate.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Compare each accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result beat, actual read_data %h irq_level %b",
                 $time, out_read_data, out_irq_level);
        mismatches++;
      end else begin
        exp_r = due_results.pop_front();
        if (out_read_data !== exp_r.read_data) begin
          $display("%0t: read_data mismatch, expected %h, actual %h",
                   $time, exp_r.read_data, out_read_data);
          mismatches++;
        end
        if (out_irq_level !== exp_r.irq_level) begin
          $display("%0t: irq_level mismatch, expected %b, actual %b",
                   $time, exp_r.irq_level, out_irq_level);
          mismatches++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, then random segments.
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_mode       = MODE_READ;
    in_bank       = BANK_TIMER;
    in_offset     = '0;
    in_write_data = '0;
    out_stall     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_idle_pct = 20;
    recv_idle_pct = 85;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++)
      drive_beat(directed_rows[i].beat, directed_rows[i].known, directed_rows[i].want);

    // Random segments: each one starts from an idle block with a new setting.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle();
      if (seg < 2) begin
        send_idle_pct = 20;
        recv_idle_pct = 85;
      end else if (seg < 4) begin
        send_idle_pct = 85;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_ticks_per_ms({16'($urandom()), tpm_plan[seg]});
      for (int n = 0; n < BEATS_PER_SEGMENT; n++)
        drive_beat(random_beat(), 1'b0, '0);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/ptmr_pkg.sv
hw/rtl/ptmr_core.sv
hw/rtl/periodic_timer_with_ms_counter_regs.sv
sim/periodic_timer_with_ms_counter_regs_tb.sv
